FILE: rtl/assert_macros.svh
// assertion helpers, clocked on i_clk and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define RTMI_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RTMI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RTMI_ASSERT_IMPLY(lbl, ante, cons)
`define RTMI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/rtmi_pkg.sv
// ----------------------------------------------------------------------------
// rtmi_pkg
// types, constants and the arithmetic op sequence of the intersect core
// ----------------------------------------------------------------------------
`default_nettype none
package rtmi_pkg;

    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_NORMAL = 2'd1;
    localparam logic [1:0] KIND_FACE   = 2'd2;
    localparam logic [1:0] KIND_CAST   = 2'd3;

    localparam int IDX_W  = 12;
    localparam int CNT_W  = 13;
    localparam int OP_W   = 5;
    localparam logic [OP_W-1:0] OP_COUNT = 5'd27;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vec;

    typedef struct packed {
        logic [IDX_W-1:0] va;
        logic [IDX_W-1:0] vb;
        logic [IDX_W-1:0] vc;
        logic [IDX_W-1:0] ta;
        logic [IDX_W-1:0] tb;
        logic [IDX_W-1:0] tc;
        logic [IDX_W-1:0] nr;
    } t_face;

    typedef enum logic [2:0] {V_DIR, V_E1, V_E2, V_TV, V_P, V_Q, V_NRM} t_vsel;
    typedef enum logic [1:0] {C_X, C_Y, C_Z} t_comp;
    typedef enum logic [2:0] {D_NONE, D_PX, D_PY, D_PZ, D_QX, D_QY, D_QZ} t_dst;
    typedef enum logic [2:0] {A_NONE, A_DET, A_U, A_V, A_T, A_DEN} t_act;

    typedef struct packed {
        t_vsel a_vec;
        t_comp a_comp;
        t_vsel b_vec;
        t_comp b_comp;
        logic  sub;
        logic  first;
        t_dst  dst;
        t_act  act;
    } t_op;

    function automatic t_op mk_op(input t_vsel av, input t_comp ac, input t_vsel bv,
                                  input t_comp bc, input logic sb, input logic fs,
                                  input t_dst d, input t_act a);
        t_op o;
        o.a_vec = av; o.a_comp = ac; o.b_vec = bv; o.b_comp = bc;
        o.sub = sb; o.first = fs; o.dst = d; o.act = a;
        return o;
    endfunction

    // p = dir x e2, det = p.e1, p.tv, q = tv x e1, q.dir, q.e2, nrm.nrm
    function automatic t_op op_rom(input logic [OP_W-1:0] idx);
        t_op o;
        unique case (idx)
            5'd0:  o = mk_op(V_DIR, C_Y, V_E2, C_Z, 1'b0, 1'b1, D_NONE, A_NONE);
            5'd1:  o = mk_op(V_DIR, C_Z, V_E2, C_Y, 1'b1, 1'b0, D_PX, A_NONE);
            5'd2:  o = mk_op(V_DIR, C_Z, V_E2, C_X, 1'b0, 1'b1, D_NONE, A_NONE);
            5'd3:  o = mk_op(V_DIR, C_X, V_E2, C_Z, 1'b1, 1'b0, D_PY, A_NONE);
            5'd4:  o = mk_op(V_DIR, C_X, V_E2, C_Y, 1'b0, 1'b1, D_NONE, A_NONE);
            5'd5:  o = mk_op(V_DIR, C_Y, V_E2, C_X, 1'b1, 1'b0, D_PZ, A_NONE);
            5'd6:  o = mk_op(V_P, C_X, V_E1, C_X, 1'b0, 1'b1, D_NONE, A_NONE);
            5'd7:  o = mk_op(V_P, C_Y, V_E1, C_Y, 1'b0, 1'b0, D_NONE, A_NONE);
            5'd8:  o = mk_op(V_P, C_Z, V_E1, C_Z, 1'b0, 1'b0, D_NONE, A_DET);
            5'd9:  o = mk_op(V_P, C_X, V_TV, C_X, 1'b0, 1'b1, D_NONE, A_NONE);
            5'd10: o = mk_op(V_P, C_Y, V_TV, C_Y, 1'b0, 1'b0, D_NONE, A_NONE);
            5'd11: o = mk_op(V_P, C_Z, V_TV, C_Z, 1'b0, 1'b0, D_NONE, A_U);
            5'd12: o = mk_op(V_TV, C_Y, V_E1, C_Z, 1'b0, 1'b1, D_NONE, A_NONE);
            5'd13: o = mk_op(V_TV, C_Z, V_E1, C_Y, 1'b1, 1'b0, D_QX, A_NONE);
            5'd14: o = mk_op(V_TV, C_Z, V_E1, C_X, 1'b0, 1'b1, D_NONE, A_NONE);
            5'd15: o = mk_op(V_TV, C_X, V_E1, C_Z, 1'b1, 1'b0, D_QY, A_NONE);
            5'd16: o = mk_op(V_TV, C_X, V_E1, C_Y, 1'b0, 1'b1, D_NONE, A_NONE);
            5'd17: o = mk_op(V_TV, C_Y, V_E1, C_X, 1'b1, 1'b0, D_QZ, A_NONE);
            5'd18: o = mk_op(V_Q, C_X, V_DIR, C_X, 1'b0, 1'b1, D_NONE, A_NONE);
            5'd19: o = mk_op(V_Q, C_Y, V_DIR, C_Y, 1'b0, 1'b0, D_NONE, A_NONE);
            5'd20: o = mk_op(V_Q, C_Z, V_DIR, C_Z, 1'b0, 1'b0, D_NONE, A_V);
            5'd21: o = mk_op(V_Q, C_X, V_E2, C_X, 1'b0, 1'b1, D_NONE, A_NONE);
            5'd22: o = mk_op(V_Q, C_Y, V_E2, C_Y, 1'b0, 1'b0, D_NONE, A_NONE);
            5'd23: o = mk_op(V_Q, C_Z, V_E2, C_Z, 1'b0, 1'b0, D_NONE, A_T);
            5'd24: o = mk_op(V_NRM, C_X, V_NRM, C_X, 1'b0, 1'b1, D_NONE, A_NONE);
            5'd25: o = mk_op(V_NRM, C_Y, V_NRM, C_Y, 1'b0, 1'b0, D_NONE, A_NONE);
            5'd26: o = mk_op(V_NRM, C_Z, V_NRM, C_Z, 1'b0, 1'b0, D_NONE, A_DEN);
            default: o = mk_op(V_DIR, C_X, V_DIR, C_X, 1'b0, 1'b1, D_NONE, A_NONE);
        endcase
        return o;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
        logic signed [31:0] r;
        if (x > 35'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (x < -35'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic t_vec vsub(input t_vec a, input t_vec b);
        t_vec r;
        r.x = sat32(35'(a.x) - 35'(b.x));
        r.y = sat32(35'(a.y) - 35'(b.y));
        r.z = sat32(35'(a.z) - 35'(b.z));
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/ray_triangle_mesh_intersect_core.sv
// ----------------------------------------------------------------------------
// ray_triangle_mesh_intersect_core
// mesh stores and first-hit ray caster over stored faces
// ----------------------------------------------------------------------------
// input channel: i_valid / o_stall. kinds 0..2 write one store entry and are
// taken without stalling, giving no result. kind 3 casts a ray: the core
// stalls its input until the result is handed to the output register.
// output channel: o_valid / i_stall, one result per cast, held while stalled.
// a cast may be taken while an earlier result still waits.
// per tested face: store reads of the face record and its vertices, multiply
// steps on the single shared multiplier (up to 27 steps) and divisions on the
// single serial divider (up to 5 divisions). o_valid rises when the cast's
// result is handed to the output register, and the input is free again from
// then on. a stalled earlier result holds the cast in its done state until it
// leaves. i_cfg_we writes the face limit; the user must do so only while
// idle, the block itself does not enforce this. reset clears control and the
// face limit; store contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none
module ray_triangle_mesh_intersect_core #(
    parameter int VERTEX_DEPTH = 4096,
    parameter int NORMAL_DEPTH = 4096,
    parameter int FACE_DEPTH   = 4096,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [12:0]        i_cfg_wdata,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_kind,
    input  wire logic [11:0]        i_slot,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic signed [31:0] i_dir_x,
    input  wire logic signed [31:0] i_dir_y,
    input  wire logic signed [31:0] i_dir_z,
    input  wire logic [11:0]        i_normal_ref,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_hit,
    output logic signed [31:0]      o_distance,
    output logic signed [31:0]      o_bary_u,
    output logic signed [31:0]      o_bary_v,
    output logic signed [31:0]      o_hit_normal_x,
    output logic signed [31:0]      o_hit_normal_y,
    output logic signed [31:0]      o_hit_normal_z,
    output logic [11:0]             o_face_hit,
    output logic [11:0]             o_tex_a,
    output logic [11:0]             o_tex_b,
    output logic [11:0]             o_tex_c
);
    import rtmi_pkg::*;

    localparam int VAW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int NAW = (NORMAL_DEPTH > 1) ? $clog2(NORMAL_DEPTH) : 1;
    localparam int FAW = (FACE_DEPTH > 1) ? $clog2(FACE_DEPTH) : 1;
    localparam logic signed [31:0] ONE = 32'(64'd1 << FRAC_BITS);

    typedef enum logic [3:0] {
        S_IDLE, S_FRD, S_VA, S_VB, S_VC, S_EDGE, S_MUL, S_ACC,
        S_DIV, S_NRD, S_NW, S_DONE
    } t_state;
    typedef enum logic [2:0] {K_U, K_V, K_T, K_DU, K_DV} t_divk;

    // stores
    t_vec  vmem [VERTEX_DEPTH];
    t_vec  nmem [NORMAL_DEPTH];
    t_face fmem [FACE_DEPTH];

    t_state        r_state;
    t_divk         r_divk;
    logic [12:0]   r_cfg;
    logic [CNT_W-1:0] r_fi;
    logic [OP_W-1:0]  r_op;
    t_vec          r_org, r_dir, r_v0, r_v1, r_e1, r_e2, r_tv, r_p, r_q, r_nrm;
    t_face         r_frec;
    t_vec          r_vraw, r_nraw;
    logic          r_voob, r_noob;
    logic signed [34:0] r_acc;
    logic signed [31:0] r_det, r_den, r_u, r_v, r_t;
    logic          r_dstart;
    logic signed [31:0] r_dnum, r_dden;
    logic          r_found;
    logic          r_ovalid;
    logic          r_ohit;
    logic signed [31:0] r_odist, r_ou, r_ov, r_onx, r_ony, r_onz;
    logic [11:0]   r_oface, r_ota, r_otb, r_otc;

    logic          in_acc;
    logic [IDX_W-1:0] vidx;
    t_vec          vdat, ndat;
    t_op           op;
    t_vec          avec, bvec;
    logic signed [31:0] opa, opb, mul_res;
    logic signed [34:0] term, acc_new;
    logic signed [31:0] acc_sat;
    logic          div_busy, div_done;
    logic signed [31:0] div_q;
    logic [CNT_W-1:0] fi_next;
    logic          more;

    assign in_acc  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);

    // store writes
    always_ff @(posedge i_clk) begin
        if (in_acc && i_kind == KIND_VERTEX && 32'(i_slot) < VERTEX_DEPTH) begin
            vmem[VAW'(i_slot)] <= '{x: i_pos_x, y: i_pos_y, z: i_pos_z};
        end
        if (in_acc && i_kind == KIND_NORMAL && 32'(i_slot) < NORMAL_DEPTH) begin
            nmem[NAW'(i_slot)] <= '{x: i_pos_x, y: i_pos_y, z: i_pos_z};
        end
        if (in_acc && i_kind == KIND_FACE && 32'(i_slot) < FACE_DEPTH) begin
            fmem[FAW'(i_slot)] <= '{va: i_pos_x[11:0], vb: i_pos_y[11:0],
                                    vc: i_pos_z[11:0], ta: i_dir_x[11:0],
                                    tb: i_dir_y[11:0], tc: i_dir_z[11:0],
                                    nr: i_normal_ref};
        end
    end

    // store reads
    always_comb begin
        unique case (r_state)
            S_VB:    vidx = r_frec.vb;
            S_VC:    vidx = r_frec.vc;
            default: vidx = r_frec.va;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_frec <= fmem[FAW'(r_fi)];
        r_vraw <= vmem[VAW'(vidx)];
        r_voob <= !(32'(vidx) < VERTEX_DEPTH);
        r_nraw <= nmem[NAW'(r_frec.nr)];
        r_noob <= !(32'(r_frec.nr) < NORMAL_DEPTH);
    end

    assign vdat = r_voob ? '0 : r_vraw;
    assign ndat = r_noob ? '0 : r_nraw;

    // operand select for the shared multiplier
    assign op = op_rom(r_op);

    function automatic t_vec pick_vec(input t_vsel s, input t_vec d, input t_vec e1,
                                      input t_vec e2, input t_vec tv, input t_vec p,
                                      input t_vec q, input t_vec n);
        t_vec r;
        unique case (s)
            V_DIR:   r = d;
            V_E1:    r = e1;
            V_E2:    r = e2;
            V_TV:    r = tv;
            V_P:     r = p;
            V_Q:     r = q;
            V_NRM:   r = n;
            default: r = d;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] pick_comp(input t_vec v, input t_comp c);
        logic signed [31:0] r;
        unique case (c)
            C_X:     r = v.x;
            C_Y:     r = v.y;
            default: r = v.z;
        endcase
        return r;
    endfunction

    assign avec = pick_vec(op.a_vec, r_dir, r_e1, r_e2, r_tv, r_p, r_q, r_nrm);
    assign bvec = pick_vec(op.b_vec, r_dir, r_e1, r_e2, r_tv, r_p, r_q, r_nrm);
    assign opa  = pick_comp(avec, op.a_comp);
    assign opb  = pick_comp(bvec, op.b_comp);

    rtmi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk (i_clk),
        .i_a   (opa),
        .i_b   (opb),
        .o_res (mul_res)
    );

    rtmi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (r_dnum),
        .i_den   (r_dden),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    assign term    = op.sub ? -35'(mul_res) : 35'(mul_res);
    assign acc_new = op.first ? term : r_acc + term;
    assign acc_sat = sat32(acc_new);

    assign fi_next = r_fi + 1'b1;
    assign more    = (fi_next < r_cfg) && (32'(fi_next) < FACE_DEPTH);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg    <= '0;
            r_ovalid <= 1'b0;
            r_dstart <= 1'b0;
            r_found  <= 1'b0;
            r_fi     <= '0;
            r_op     <= '0;
            r_divk   <= K_U;
        end else begin
            if (r_dstart) begin
                r_dstart <= 1'b0;
            end
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (r_ovalid && !i_stall && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_kind == KIND_CAST) begin
                        r_org   <= '{x: i_pos_x, y: i_pos_y, z: i_pos_z};
                        r_dir   <= '{x: i_dir_x, y: i_dir_y, z: i_dir_z};
                        r_fi    <= '0;
                        r_found <= 1'b0;
                        r_state <= (r_cfg == '0) ? S_DONE : S_FRD;
                    end
                end
                S_FRD: r_state <= S_VA;
                S_VA:  r_state <= S_VB;
                S_VB: begin
                    r_v0    <= vdat;
                    r_state <= S_VC;
                end
                S_VC: begin
                    r_v1    <= vdat;
                    r_state <= S_EDGE;
                end
                S_EDGE: begin
                    r_e1    <= vsub(r_v1, r_v0);
                    r_e2    <= vsub(vdat, r_v0);
                    r_tv    <= vsub(r_org, r_v0);
                    r_op    <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: r_state <= S_ACC;
                S_ACC: begin
                    r_acc <= acc_new;
                    r_op  <= r_op + 1'b1;
                    unique case (op.dst)
                        D_PX:    r_p.x <= acc_sat;
                        D_PY:    r_p.y <= acc_sat;
                        D_PZ:    r_p.z <= acc_sat;
                        D_QX:    r_q.x <= acc_sat;
                        D_QY:    r_q.y <= acc_sat;
                        D_QZ:    r_q.z <= acc_sat;
                        default: ;
                    endcase
                    unique case (op.act)
                        A_DET: begin
                            r_det <= acc_sat;
                            if (acc_sat <= 0) begin
                                r_fi    <= more ? fi_next : r_fi;
                                r_state <= more ? S_FRD : S_DONE;
                            end else begin
                                r_state <= S_MUL;
                            end
                        end
                        A_U, A_V, A_T: begin
                            r_dstart <= 1'b1;
                            r_dnum   <= acc_sat;
                            r_dden   <= r_det;
                            r_divk   <= (op.act == A_U) ? K_U :
                                        (op.act == A_V) ? K_V : K_T;
                            r_state  <= S_DIV;
                        end
                        A_DEN: begin
                            r_found <= 1'b1;
                            if (acc_sat > 0) begin
                                r_den    <= acc_sat;
                                r_dstart <= 1'b1;
                                r_dnum   <= r_u;
                                r_dden   <= acc_sat;
                                r_divk   <= K_DU;
                                r_state  <= S_DIV;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        default: r_state <= S_MUL;
                    endcase
                end
                S_DIV: begin
                    if (div_done) begin
                        unique case (r_divk)
                            K_U: begin
                                r_u <= div_q;
                                if (div_q < 0 || div_q > ONE) begin
                                    r_fi    <= more ? fi_next : r_fi;
                                    r_state <= more ? S_FRD : S_DONE;
                                end else begin
                                    r_state <= S_MUL;
                                end
                            end
                            K_V: begin
                                r_v <= div_q;
                                if (div_q < 0 || (33'(r_u) + 33'(div_q)) > 33'(ONE)) begin
                                    r_fi    <= more ? fi_next : r_fi;
                                    r_state <= more ? S_FRD : S_DONE;
                                end else begin
                                    r_state <= S_MUL;
                                end
                            end
                            K_T: begin
                                r_t <= div_q;
                                if (div_q <= 0) begin
                                    r_fi    <= more ? fi_next : r_fi;
                                    r_state <= more ? S_FRD : S_DONE;
                                end else begin
                                    r_state <= S_NRD;
                                end
                            end
                            K_DU: begin
                                r_u      <= div_q;
                                r_dstart <= 1'b1;
                                r_dnum   <= r_v;
                                r_dden   <= r_den;
                                r_divk   <= K_DV;
                            end
                            default: begin
                                r_v     <= div_q;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_NRD: r_state <= S_NW;
                S_NW: begin
                    r_nrm   <= ndat;
                    r_state <= S_MUL;
                end
                S_DONE: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_ohit   <= r_found;
                        r_odist  <= r_found ? r_t : '0;
                        r_ou     <= r_found ? r_u : '0;
                        r_ov     <= r_found ? r_v : '0;
                        r_onx    <= r_found ? r_nrm.x : '0;
                        r_ony    <= r_found ? r_nrm.y : '0;
                        r_onz    <= r_found ? r_nrm.z : '0;
                        r_oface  <= r_found ? r_fi[11:0] : '0;
                        r_ota    <= r_found ? r_frec.ta : '0;
                        r_otb    <= r_found ? r_frec.tb : '0;
                        r_otc    <= r_found ? r_frec.tc : '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_hit          = r_ohit;
    assign o_distance     = r_odist;
    assign o_bary_u       = r_ou;
    assign o_bary_v       = r_ov;
    assign o_hit_normal_x = r_onx;
    assign o_hit_normal_y = r_ony;
    assign o_hit_normal_z = r_onz;
    assign o_face_hit     = r_oface;
    assign o_tex_a        = r_ota;
    assign o_tex_b        = r_otb;
    assign o_tex_c        = r_otc;

`include "assert_macros.svh"

    `RTMI_ASSERT_NEXT(a_cast_stalls, in_acc && i_kind == KIND_CAST, o_stall)
    `RTMI_ASSERT_IMPLY(a_op_range, r_state == S_MUL || r_state == S_ACC, r_op < OP_COUNT)
    `RTMI_ASSERT_IMPLY(a_hit_dist, o_valid && o_hit, o_distance > 0)
    `RTMI_ASSERT_IMPLY(a_div_idle_start, r_dstart, !div_busy)

endmodule
`default_nettype wire

FILE: rtl/rtmi_mul.sv
// ----------------------------------------------------------------------------
// rtmi_mul
// shared fixed point multiplier: registered product, floor shift, saturate
// ----------------------------------------------------------------------------
`default_nettype none
module rtmi_mul #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic signed [31:0]      o_res
);
    logic signed [63:0] r_prod;
    logic signed [63:0] shifted;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    always_comb begin
        shifted = r_prod >>> FRAC_BITS;
        if (shifted > 64'sd2147483647) begin
            o_res = 32'sh7fff_ffff;
        end else if (shifted < -64'sd2147483648) begin
            o_res = 32'sh8000_0000;
        end else begin
            o_res = shifted[31:0];
        end
    end
endmodule
`default_nettype wire

FILE: rtl/rtmi_div.sv
// ----------------------------------------------------------------------------
// rtmi_div
// radix-2 restoring divider: num * 2^frac / den, den positive, saturated
// ----------------------------------------------------------------------------
`default_nettype none
module rtmi_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_num,
    input  wire logic signed [31:0] i_den,
    output logic                    o_busy,
    output logic                    o_done,
    output logic signed [31:0]      o_quo
);
    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);
    localparam logic [NW-1:0] POS_LIM = NW'(64'h7fff_ffff);
    localparam logic [NW-1:0] NEG_LIM = NW'(64'h8000_0000);

    logic [NW-1:0] r_n;
    logic [NW-1:0] r_q;
    logic [31:0]   r_rem;
    logic [31:0]   r_den;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [31:0]   mag;
    logic [32:0]   rem_sh;
    logic          fits;
    logic [NW-1:0] q_neg;

    assign mag    = i_num[31] ? 32'(-i_num) : 32'(i_num);
    assign rem_sh = {r_rem, r_n[NW-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= {mag, {FRAC_BITS{1'b0}}};
            r_q   <= '0;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[31];
        end else if (r_busy) begin
            r_n   <= {r_n[NW-2:0], 1'b0};
            r_q   <= {r_q[NW-2:0], fits};
            r_rem <= fits ? 32'(rem_sh - {1'b0, r_den}) : rem_sh[31:0];
        end
    end

    always_comb begin
        q_neg = -r_q;
        if (r_neg) begin
            o_quo = (r_q > NEG_LIM) ? 32'sh8000_0000 : q_neg[31:0];
        end else begin
            o_quo = (r_q > POS_LIM) ? 32'sh7fff_ffff : r_q[31:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
endmodule
`default_nettype wire

FILE: bench/ray_hit_checker.sv
// ----------------------------------------------------------------------------
// ray_hit_checker
// watches both channels and the face limit port of the intersect core, keeps
// its own copy of the mesh stores, predicts the first-hit result of each cast
// and compares every returned result field by field
// ----------------------------------------------------------------------------
`default_nettype none
module ray_hit_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [12:0]        i_cfg_wdata,
    input  wire logic               i_valid,
    input  wire logic               i_o_stall,
    input  wire logic [1:0]         i_kind,
    input  wire logic [11:0]        i_slot,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic signed [31:0] i_dir_x,
    input  wire logic signed [31:0] i_dir_y,
    input  wire logic signed [31:0] i_dir_z,
    input  wire logic [11:0]        i_normal_ref,
    input  wire logic               i_o_valid,
    input  wire logic               i_stall,
    input  wire logic               i_hit,
    input  wire logic signed [31:0] i_distance,
    input  wire logic signed [31:0] i_bary_u,
    input  wire logic signed [31:0] i_bary_v,
    input  wire logic signed [31:0] i_hit_normal_x,
    input  wire logic signed [31:0] i_hit_normal_y,
    input  wire logic signed [31:0] i_hit_normal_z,
    input  wire logic [11:0]        i_face_hit,
    input  wire logic [11:0]        i_tex_a,
    input  wire logic [11:0]        i_tex_b,
    input  wire logic [11:0]        i_tex_c,
    output int                      o_fail_count,
    output int                      o_pending
);
    import rtmi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC  = 16;
    localparam int DEPTH = 4096;

    typedef struct {
        longint x;
        longint y;
        longint z;
    } fx_vec;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] tdist;
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic [11:0]        face;
        logic [11:0]        ta;
        logic [11:0]        tb;
        logic [11:0]        tc;
    } hit_rec;

    t_vec   vtx_mem [DEPTH];
    t_vec   nrm_mem [DEPTH];
    t_face  face_mem[DEPTH];
    int     face_limit;
    hit_rec expected_hits[$];

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return clamp32((a * b) >>> FRAC);
    endfunction

    function automatic longint fx_div(longint num, longint den);
        return clamp32((num * (64'sd1 <<< FRAC)) / den);
    endfunction

    function automatic longint fx_dot(fx_vec a, fx_vec b);
        return clamp32(fx_mul(a.x, b.x) + fx_mul(a.y, b.y) + fx_mul(a.z, b.z));
    endfunction

    function automatic fx_vec fx_cross(fx_vec a, fx_vec b);
        fx_vec r;
        r.x = clamp32(fx_mul(a.y, b.z) - fx_mul(a.z, b.y));
        r.y = clamp32(fx_mul(a.z, b.x) - fx_mul(a.x, b.z));
        r.z = clamp32(fx_mul(a.x, b.y) - fx_mul(a.y, b.x));
        return r;
    endfunction

    function automatic fx_vec fx_sub(fx_vec a, fx_vec b);
        fx_vec r;
        r.x = clamp32(a.x - b.x);
        r.y = clamp32(a.y - b.y);
        r.z = clamp32(a.z - b.z);
        return r;
    endfunction

    function automatic fx_vec widen(t_vec w);
        fx_vec r;
        r.x = longint'(w.x);
        r.y = longint'(w.y);
        r.z = longint'(w.z);
        return r;
    endfunction

    function automatic hit_rec trace_first_hit(fx_vec org, fx_vec dir);
        hit_rec r;
        t_face  f;
        fx_vec  v0, e1, e2, p, tv, q, nv;
        longint det, u, v, t, den;
        int     n;
        r = '0;
        n = (face_limit < DEPTH) ? face_limit : DEPTH;
        for (int i = 0; i < n; i++) begin
            f  = face_mem[i];
            v0 = widen(vtx_mem[f.va]);
            e1 = fx_sub(widen(vtx_mem[f.vb]), v0);
            e2 = fx_sub(widen(vtx_mem[f.vc]), v0);
            p  = fx_cross(dir, e2);
            det = fx_dot(p, e1);
            if (det <= 0) continue;
            tv = fx_sub(org, v0);
            u  = fx_div(fx_dot(p, tv), det);
            if (u < 0 || u > (64'sd1 <<< FRAC)) continue;
            q  = fx_cross(tv, e1);
            v  = fx_div(fx_dot(q, dir), det);
            if (v < 0 || u + v > (64'sd1 <<< FRAC)) continue;
            t  = fx_div(fx_dot(q, e2), det);
            if (t <= 0) continue;
            nv  = widen(nrm_mem[f.nr]);
            den = fx_dot(nv, nv);
            if (den > 0) begin
                u = fx_div(u, den);
                v = fx_div(v, den);
            end
            r.hit   = 1'b1;
            r.tdist = t[31:0];
            r.u     = u[31:0];
            r.v     = v[31:0];
            r.nx    = nv.x[31:0];
            r.ny    = nv.y[31:0];
            r.nz    = nv.z[31:0];
            r.face  = i[11:0];
            r.ta    = f.ta;
            r.tb    = f.tb;
            r.tc    = f.tc;
            break;
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("%0t mismatch on %s: expected %h, got %h", $realtime, name,
                         exp_val, act_val);
            end
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        face_limit   = 0;
    end

    always @(posedge i_clk) begin
        fx_vec  org, dir;
        hit_rec e;
        if (!i_rst_n) begin
            face_limit = 0;
        end else begin
            if (i_cfg_we) begin
                face_limit = int'(i_cfg_wdata);
            end
            if (i_valid && !i_o_stall) begin
                case (i_kind)
                    KIND_VERTEX: vtx_mem[i_slot] = '{i_pos_x, i_pos_y, i_pos_z};
                    KIND_NORMAL: nrm_mem[i_slot] = '{i_pos_x, i_pos_y, i_pos_z};
                    KIND_FACE: begin
                        face_mem[i_slot] = '{i_pos_x[11:0], i_pos_y[11:0], i_pos_z[11:0],
                                             i_dir_x[11:0], i_dir_y[11:0], i_dir_z[11:0],
                                             i_normal_ref};
                    end
                    default: begin
                        org.x = longint'(i_pos_x);
                        org.y = longint'(i_pos_y);
                        org.z = longint'(i_pos_z);
                        dir.x = longint'(i_dir_x);
                        dir.y = longint'(i_dir_y);
                        dir.z = longint'(i_dir_z);
                        expected_hits.push_back(trace_first_hit(org, dir));
                    end
                endcase
            end
            if (i_o_valid && !i_stall) begin
                if (expected_hits.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("%0t result with no cast request pending", $realtime);
                    end
                end else begin
                    e = expected_hits.pop_front();
                    check_field("hit", 32'(e.hit), 32'(i_hit));
                    check_field("distance", e.tdist, i_distance);
                    check_field("bary_u", e.u, i_bary_u);
                    check_field("bary_v", e.v, i_bary_v);
                    check_field("hit_normal_x", e.nx, i_hit_normal_x);
                    check_field("hit_normal_y", e.ny, i_hit_normal_y);
                    check_field("hit_normal_z", e.nz, i_hit_normal_z);
                    check_field("face_hit", 32'(e.face), 32'(i_face_hit));
                    check_field("tex_a", 32'(e.ta), 32'(i_tex_a));
                    check_field("tex_b", 32'(e.tb), 32'(i_tex_b));
                    check_field("tex_c", 32'(e.tc), 32'(i_tex_c));
                end
            end
        end
        o_pending = expected_hits.size();
    end

endmodule
`default_nettype wire

FILE: bench/tb_ray_triangle_mesh_intersect_core.sv
// ----------------------------------------------------------------------------
// tb_ray_triangle_mesh_intersect_core
// loads small meshes into the intersect core and casts directed and random
// rays under several face counts, with random gaps and stalls on both sides,
// one long output hold and drain pauses; a checker module judges each result
// ----------------------------------------------------------------------------
`default_nettype none
module tb_ray_triangle_mesh_intersect_core;
    import rtmi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ONE_Q = 65536;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [12:0]        i_cfg_wdata;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_kind;
    logic [11:0]        i_slot;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [31:0] i_dir_x, i_dir_y, i_dir_z;
    logic [11:0]        i_normal_ref;
    logic               o_valid;
    logic               i_stall;
    logic               o_hit;
    logic signed [31:0] o_distance, o_bary_u, o_bary_v;
    logic signed [31:0] o_hit_normal_x, o_hit_normal_y, o_hit_normal_z;
    logic [11:0]        o_face_hit, o_tex_a, o_tex_b, o_tex_c;
    int                 fail_count;
    int                 pending;

    bit                 no_gaps;
    bit                 long_hold_req;
    int                 vtx_slots[$];
    int                 nrm_slots[$];

    always #5 i_clk = ~i_clk;

    ray_triangle_mesh_intersect_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_kind(i_kind), .i_slot(i_slot),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_dir_x(i_dir_x), .i_dir_y(i_dir_y), .i_dir_z(i_dir_z),
        .i_normal_ref(i_normal_ref),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_hit(o_hit), .o_distance(o_distance),
        .o_bary_u(o_bary_u), .o_bary_v(o_bary_v),
        .o_hit_normal_x(o_hit_normal_x), .o_hit_normal_y(o_hit_normal_y),
        .o_hit_normal_z(o_hit_normal_z),
        .o_face_hit(o_face_hit), .o_tex_a(o_tex_a), .o_tex_b(o_tex_b), .o_tex_c(o_tex_c)
    );

    ray_hit_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .i_o_stall(o_stall),
        .i_kind(i_kind), .i_slot(i_slot),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_dir_x(i_dir_x), .i_dir_y(i_dir_y), .i_dir_z(i_dir_z),
        .i_normal_ref(i_normal_ref),
        .i_o_valid(o_valid), .i_stall(i_stall),
        .i_hit(o_hit), .i_distance(o_distance),
        .i_bary_u(o_bary_u), .i_bary_v(o_bary_v),
        .i_hit_normal_x(o_hit_normal_x), .i_hit_normal_y(o_hit_normal_y),
        .i_hit_normal_z(o_hit_normal_z),
        .i_face_hit(o_face_hit), .i_tex_a(o_tex_a), .i_tex_b(o_tex_b), .i_tex_c(o_tex_c),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int rand_q(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [31:0] index_word(int idx);
        logic [31:0] w;
        w = $urandom();
        w[11:0] = idx[11:0];
        return w;
    endfunction

    task automatic send_request(logic [1:0] kind, logic [11:0] slot,
                                logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                                logic [11:0] nref);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_kind <= kind; i_slot <= slot;
        i_pos_x <= px; i_pos_y <= py; i_pos_z <= pz;
        i_dir_x <= dx; i_dir_y <= dy; i_dir_z <= dz;
        i_normal_ref <= nref;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic put_vertex(int slot, int x, int y, int z);
        send_request(KIND_VERTEX, slot[11:0], x, y, z, $urandom(), $urandom(), $urandom(),
                     12'($urandom()));
        if (!(slot inside {vtx_slots})) vtx_slots.push_back(slot);
    endtask

    task automatic put_normal(int slot, int x, int y, int z);
        send_request(KIND_NORMAL, slot[11:0], x, y, z, $urandom(), $urandom(), $urandom(),
                     12'($urandom()));
        if (!(slot inside {nrm_slots})) nrm_slots.push_back(slot);
    endtask

    task automatic put_face(int slot, int a, int b, int c, logic [31:0] ta,
                            logic [31:0] tb, logic [31:0] tc, int nref);
        send_request(KIND_FACE, slot[11:0], index_word(a), index_word(b), index_word(c),
                     ta, tb, tc, nref[11:0]);
    endtask

    task automatic cast_ray(int ox, int oy, int oz, int dx, int dy, int dz);
        send_request(KIND_CAST, 12'($urandom()), ox, oy, oz, dx, dy, dz, 12'($urandom()));
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_face_count(int n);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= n[12:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_face(int slot);
        put_face(slot, vtx_slots[$urandom_range(0, vtx_slots.size() - 1)],
                 vtx_slots[$urandom_range(0, vtx_slots.size() - 1)],
                 vtx_slots[$urandom_range(0, vtx_slots.size() - 1)],
                 $urandom(), $urandom(), $urandom(),
                 nrm_slots[$urandom_range(0, nrm_slots.size() - 1)]);
    endtask

    task automatic random_cast();
        int ox, oy, oz;
        if ($urandom_range(0, 99) < 85) begin
            ox = rand_q(3 * ONE_Q); oy = rand_q(3 * ONE_Q); oz = rand_q(3 * ONE_Q);
            cast_ray(ox, oy, oz, rand_q(ONE_Q) - ox, rand_q(ONE_Q) - oy, rand_q(ONE_Q) - oz);
        end else begin
            cast_ray($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        end
    endtask

    task automatic random_item();
        int sel, slot;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            random_cast();
        end else if (sel < 60) begin
            slot = ($urandom_range(0, 9) < 7) ? $urandom_range(3, 31) : $urandom_range(3, 4095);
            if ($urandom_range(0, 4) == 0) begin
                put_vertex(slot, $urandom(), $urandom(), $urandom());
            end else begin
                put_vertex(slot, rand_q(2 * ONE_Q), rand_q(2 * ONE_Q), rand_q(2 * ONE_Q));
            end
        end else if (sel < 70) begin
            slot = $urandom_range(0, 4095);
            case ($urandom_range(0, 3))
                0: put_normal(slot, 0, 0, 0);
                1: put_normal(slot, $urandom(), $urandom(), $urandom());
                default: put_normal(slot, rand_q(2 * ONE_Q), rand_q(2 * ONE_Q),
                                    rand_q(2 * ONE_Q));
            endcase
        end else begin
            random_face(($urandom_range(0, 99) < 85) ? $urandom_range(1, 15)
                                                     : $urandom_range(16, 4095));
        end
    endtask

    // output side: per-result stall draw, plus one long hold on request
    initial begin
        int hold_left;
        hold_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (o_valid && !i_stall && !no_gaps) hold_left = $urandom_range(0, 5);
                if (long_hold_req) begin
                    long_hold_req = 1'b0;
                    hold_left = 3000;
                end
                if (hold_left > 0) begin
                    hold_left--;
                    i_stall <= 1'b1;
                end else begin
                    i_stall <= 1'b0;
                end
            end
        end
    end

    initial begin
        #100_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        no_gaps       = 1'b0;
        long_hold_req = 1'b0;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;
        i_valid      <= 1'b0;
        i_kind       <= KIND_VERTEX;
        i_slot       <= '0;
        i_pos_x      <= '0; i_pos_y <= '0; i_pos_z <= '0;
        i_dir_x      <= '0; i_dir_y <= '0; i_dir_z <= '0;
        i_normal_ref <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unit triangle in z = 0, an extreme vertex and extreme normals
        put_vertex(0, 0, 0, 0);
        put_vertex(1, ONE_Q, 0, 0);
        put_vertex(2, 0, ONE_Q, 0);
        put_vertex(4095, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        put_normal(0, 0, 0, ONE_Q);
        put_normal(4095, 0, 0, 0);
        put_normal(1, 2 * ONE_Q, 0, 0);
        put_normal(2, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        put_face(0, 0, 1, 2, 4095, 0, 7, 0);
        put_face(1, 0, 1, 2, 1, 2, 3, 4095);
        put_face(2, 0, 1, 4095, 5, 6, 7, 2);
        // no faces tested: miss
        cast_ray(ONE_Q / 4, ONE_Q / 4, ONE_Q, 0, 0, -ONE_Q);
        drain_results();

        set_face_count(1);
        cast_ray(ONE_Q / 4, ONE_Q / 4, ONE_Q, 0, 0, -ONE_Q);
        cast_ray(ONE_Q / 4, ONE_Q / 4, -ONE_Q, 0, 0, ONE_Q);
        cast_ray(ONE_Q / 4, ONE_Q / 4, -ONE_Q, 0, 0, -ONE_Q);
        cast_ray(2 * ONE_Q, ONE_Q / 4, ONE_Q, 0, 0, -ONE_Q);
        cast_ray(ONE_Q / 4, 2 * ONE_Q, ONE_Q, 0, 0, -ONE_Q);
        cast_ray(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        drain_results();

        set_face_count(3);
        cast_ray(2 * ONE_Q, ONE_Q / 4, ONE_Q, 0, 0, -ONE_Q);
        cast_ray(ONE_Q / 2, ONE_Q / 2, ONE_Q, 0, 0, -ONE_Q);
        cast_ray(ONE_Q / 4, ONE_Q / 4, ONE_Q / 2, 0, 0, -ONE_Q / 2);
        drain_results();

        // fill the rest of a 16-face mesh before larger counts
        for (int i = 3; i < 16; i++) put_vertex(i, rand_q(2 * ONE_Q), rand_q(2 * ONE_Q),
                                                rand_q(2 * ONE_Q));
        for (int i = 3; i < 8; i++) put_normal(i, rand_q(2 * ONE_Q), rand_q(2 * ONE_Q),
                                               rand_q(2 * ONE_Q));
        for (int i = 3; i < 16; i++) random_face(i);
        drain_results();

        for (int phase = 0; phase < 7; phase++) begin
            no_gaps = (phase == 2 || phase == 5);
            set_face_count((phase == 3) ? 16 : $urandom_range(1, 16));
            repeat (60) random_item();
            drain_results();
        end

        // long output hold with back-to-back casts
        no_gaps = 1'b1;
        set_face_count(1);
        long_hold_req = 1'b1;
        repeat (8) random_cast();
        drain_results();
        no_gaps = 1'b0;

        // counts at and past the store depth: only rays that hit face 0
        set_face_count(4096);
        cast_ray(ONE_Q / 4, ONE_Q / 4, ONE_Q, 0, 0, -ONE_Q);
        drain_results();
        set_face_count(8191);
        cast_ray(ONE_Q / 8, ONE_Q / 2, 3 * ONE_Q, 0, 0, -ONE_Q);
        drain_results();

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
